>>> src/tsu_pkg.sv
package tsu_pkg;

    localparam int ANGLE_W       = 32;
    localparam int SINE_W        = 32;
    localparam int TERM_W        = 5;
    localparam int MAG_W         = 31;
    localparam int OP_W          = 33;
    localparam int PROD_W        = 2 * OP_W;
    localparam int SUM_W         = 36;
    localparam int RECIP_W       = 28;
    localparam int RIDX_W        = 5;
    localparam int RECIP_DEPTH   = 2 ** RIDX_W;
    localparam int PC_W          = 3;
    localparam int DEF_MAX_TERMS = 16;

    localparam logic [TERM_W-1:0]         TERM_RESET = TERM_W'(16);
    localparam logic signed [ANGLE_W-1:0] PI_Q29     = 32'sd1686629713;
    localparam logic signed [SUM_W-1:0]   ONE_Q30    = 36'sd1073741824;

    // Rounded 1/((2i)(2i+1)) in Q30; entry zero is never used for a term.
    typedef logic [RECIP_W-1:0] t_recip_tab [0:RECIP_DEPTH-1];
    localparam t_recip_tab RECIP_TAB = '{
        28'd0,         28'd178956971, 28'd53687091,  28'd25565282,
        28'd14913081,  28'd9761289,   28'd6882960,   28'd5113056,
        28'd3947580,   28'd3139596,   28'd2556528,   28'd2122019,
        28'd1789570,   28'd1529547,   28'd1322342,   28'd1154561,
        28'd1016801,   28'd902304,    28'd806112,    28'd724522,
        28'd654721,    28'd594541,    28'd542294,    28'd496643,
        28'd456523,    28'd421075,    28'd389602,    28'd361529,
        28'd336385,    28'd313776,    28'd293372,    28'd274896
    };

    typedef enum logic [1:0] {
        MA_MAG = 2'd0,
        MA_T0  = 2'd1,
        MA_R30 = 2'd2,
        MA_R29 = 2'd3
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_MAG   = 2'd0,
        MB_RECIP = 2'd1,
        MB_X2    = 2'd2
    } t_mul_b;

    typedef enum logic [2:0] {
        C_GOTO     = 3'd0,
        C_WAIT_IN  = 3'd1,
        C_SKIP     = 3'd2,
        C_LOOP     = 3'd3,
        C_WAIT_OUT = 3'd4
    } t_cond;

    localparam logic [PC_W-1:0] ST_IDLE = PC_W'(0);
    localparam logic [PC_W-1:0] ST_SQ   = PC_W'(1);
    localparam logic [PC_W-1:0] ST_X2   = PC_W'(2);
    localparam logic [PC_W-1:0] ST_MX   = PC_W'(3);
    localparam logic [PC_W-1:0] ST_ACC  = PC_W'(4);
    localparam logic [PC_W-1:0] ST_FIN  = PC_W'(5);

    typedef struct packed {
        t_mul_a          mul_a;
        t_mul_b          mul_b;
        logic            mul_en;
        logic            init;
        logic            ld_x2;
        logic            acc;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef t_uword t_urom [0:(2**PC_W)-1];

    // The term loop alternates between the x squared product and the
    // accumulate step, which also starts the next reciprocal product.
    localparam t_urom UROM = '{
        '{MA_MAG, MB_MAG,   1'b0, 1'b0, 1'b0, 1'b0, C_WAIT_IN,  ST_SQ},
        '{MA_MAG, MB_MAG,   1'b1, 1'b1, 1'b0, 1'b0, C_SKIP,     ST_FIN},
        '{MA_T0,  MB_RECIP, 1'b1, 1'b0, 1'b1, 1'b0, C_GOTO,     ST_MX},
        '{MA_R30, MB_X2,    1'b1, 1'b0, 1'b0, 1'b0, C_GOTO,     ST_ACC},
        '{MA_R29, MB_RECIP, 1'b1, 1'b0, 1'b0, 1'b1, C_LOOP,     ST_MX},
        '{MA_MAG, MB_MAG,   1'b0, 1'b0, 1'b0, 1'b0, C_WAIT_OUT, ST_IDLE},
        '{MA_MAG, MB_MAG,   1'b0, 1'b0, 1'b0, 1'b0, C_GOTO,     ST_IDLE},
        '{MA_MAG, MB_MAG,   1'b0, 1'b0, 1'b0, 1'b0, C_GOTO,     ST_IDLE}
    };

endpackage

>>> src/taylor_sine_unit.sv
// Taylor series sine unit.
// The input channel (i_in_valid, o_in_stall, i_angle) takes one angle in
// radians as signed Q2.29; angles beyond plus or minus pi are clamped to plus or minus pi.
// The output channel (o_out_valid, i_out_stall, o_sine_value, o_saturated)
// returns the sine as signed Q1.30, clamped to plus or minus one, with
// o_saturated set when the clamp was applied. A transfer takes place on a
// rising edge with valid high and stall low.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) sets the
// number of terms n; 0 acts as 1 and values above MAX_TERMS act as MAX_TERMS.
// It is written only while the unit is idle; the unit itself does not enforce this.
// One item is processed at a time by a small microprogram driving a single
// shared multiplier. Each term after the first uses it for a reciprocal
// product and an x squared product; the result is registered in the final
// step, and a new angle is taken only once the unit is back in its idle step.
// The output register holds the result while i_out_stall is high; the next
// angle may already be taken and computed, and waits in the final step until
// the output register is free.
// Synchronous reset sets the term count to 16 and empties the output register.
module taylor_sine_unit #(
    parameter int MAX_TERMS = tsu_pkg::DEF_MAX_TERMS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tsu_pkg::TERM_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [tsu_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tsu_pkg::SINE_W-1:0]   o_sine_value,
    output logic                                o_saturated
);
    import tsu_pkg::*;

    localparam int IW = $clog2(MAX_TERMS + 1);

    logic [PC_W-1:0]          r_pc;
    logic [PC_W-1:0]          n_pc;
    logic [TERM_W-1:0]        r_term;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [IW-1:0]            r_n;
    logic [IW-1:0]            r_idx;
    logic [OP_W-1:0]          r_x2;
    logic signed [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [SINE_W-1:0] r_sine;
    logic                     r_sat;

    t_uword                   w_uw;
    logic                     w_in_acc;
    logic                     w_out_free;
    logic signed [ANGLE_W-1:0] w_angle;
    logic [IW-1:0]            w_n_eff;
    logic [IW-1:0]            w_nidx;
    logic                     w_end;
    logic [PROD_W-1:0]        w_rnd29;
    logic [PROD_W-1:0]        w_rnd30;
    logic [OP_W-1:0]          w_r29;
    logic [OP_W-1:0]          w_r30;
    logic [OP_W-1:0]          w_op_a;
    logic [OP_W-1:0]          w_op_b;
    logic [RECIP_W-1:0]       w_recip;
    logic signed [SUM_W-1:0]  w_term;
    logic signed [SUM_W-1:0]  w_res;

    assign w_uw       = UROM[r_pc];
    assign o_in_stall = (w_uw.cond != C_WAIT_IN);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_sine_value = r_sine;
    assign o_saturated  = r_sat;

    always_comb begin
        if (i_angle > PI_Q29) begin
            w_angle = PI_Q29;
        end else if (i_angle < -PI_Q29) begin
            w_angle = -PI_Q29;
        end else begin
            w_angle = i_angle;
        end
    end

    always_comb begin
        if (r_term == '0) begin
            w_n_eff = IW'(1);
        end else if (int'(r_term) > MAX_TERMS) begin
            w_n_eff = IW'(MAX_TERMS);
        end else begin
            w_n_eff = IW'(r_term);
        end
    end

    always_comb begin
        if (w_uw.init) begin
            w_nidx = IW'(1);
        end else if (w_uw.acc) begin
            w_nidx = r_idx + IW'(1);
        end else begin
            w_nidx = r_idx;
        end
    end

    assign w_end   = (w_nidx >= r_n);
    assign w_recip = RECIP_TAB[RIDX_W'(w_nidx)];

    assign w_rnd29 = r_prod + PROD_W'(2 ** 28);
    assign w_rnd30 = r_prod + PROD_W'(2 ** 29);
    assign w_r29   = OP_W'(w_rnd29 >> 29);
    assign w_r30   = OP_W'(w_rnd30 >> 30);
    assign w_term  = $signed(SUM_W'(w_r29));

    always_comb begin
        case (w_uw.mul_a)
            MA_MAG:  w_op_a = OP_W'(r_mag);
            MA_T0:   w_op_a = OP_W'({r_mag, 1'b0});
            MA_R30:  w_op_a = w_r30;
            MA_R29:  w_op_a = w_r29;
            default: w_op_a = '0;
        endcase
    end

    always_comb begin
        case (w_uw.mul_b)
            MB_MAG:   w_op_b = OP_W'(r_mag);
            MB_RECIP: w_op_b = OP_W'(w_recip);
            MB_X2:    w_op_b = r_x2;
            default:  w_op_b = '0;
        endcase
    end

    always_comb begin
        case (w_uw.cond)
            C_GOTO:     n_pc = w_uw.target;
            C_WAIT_IN:  n_pc = w_in_acc ? w_uw.target : r_pc;
            C_SKIP:     n_pc = w_end ? w_uw.target : r_pc + PC_W'(1);
            C_LOOP:     n_pc = w_end ? r_pc + PC_W'(1) : w_uw.target;
            C_WAIT_OUT: n_pc = w_out_free ? w_uw.target : r_pc;
            default:    n_pc = ST_IDLE;
        endcase
    end

    assign w_res = r_neg ? -r_sum : r_sum;

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (w_uw.cond == C_WAIT_OUT && w_out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_IDLE;
            r_term      <= TERM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_term <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_neg <= w_angle[ANGLE_W-1];
            r_mag <= w_angle[ANGLE_W-1] ? MAG_W'(-w_angle) : MAG_W'(w_angle);
            r_n   <= w_n_eff;
        end
        if (w_uw.mul_en) begin
            r_prod <= w_op_a * w_op_b;
        end
        if (w_uw.init) begin
            r_sum <= $signed(SUM_W'({r_mag, 1'b0}));
        end else if (w_uw.acc) begin
            r_sum <= r_idx[0] ? r_sum - w_term : r_sum + w_term;
        end
        if (w_uw.init || w_uw.acc) begin
            r_idx <= w_nidx;
        end
        if (w_uw.ld_x2) begin
            r_x2 <= w_r29;
        end
        if (w_uw.cond == C_WAIT_OUT && w_out_free) begin
            if (w_res > ONE_Q30) begin
                r_sine <= SINE_W'(ONE_Q30);
                r_sat  <= 1'b1;
            end else if (w_res < -ONE_Q30) begin
                r_sine <= SINE_W'(-ONE_Q30);
                r_sat  <= 1'b1;
            end else begin
                r_sine <= SINE_W'(w_res);
                r_sat  <= 1'b0;
            end
        end
    end

endmodule

>>> src/tsu_checker.sv
module tsu_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [tsu_pkg::SINE_W-1:0]   o_sine_value,
    input  logic                                o_saturated
);
    import tsu_pkg::*;

    localparam logic signed [SINE_W-1:0] ONE_OUT = SINE_W'(ONE_Q30);

    // A stalled result stays on the output unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_sine_value) && $stable(o_saturated))
        else $error("stalled result changed");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sine_value <= ONE_OUT) && (o_sine_value >= -ONE_OUT))
        else $error("sine value outside plus or minus one");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_sine_value == ONE_OUT) || (o_sine_value == -ONE_OUT))
        else $error("saturated result is not plus or minus one");

    // After an angle transfer the unit is busy with it in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on two consecutive cycles");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind taylor_sine_unit tsu_checker u_tsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sine_value (o_sine_value),
    .o_saturated  (o_saturated)
);
